[rtl/ntc_pkg.sv]
// shared constants and types for the thermistor adc to temperature block
// no dependencies
`timescale 1ns / 1ps

package ntc_pkg;

  // default converter width
  localparam int ADC_BITS_DEF = 10;

  // configuration port
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SERIES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VREF    = 2'd3;

  localparam int RES_W  = 20;
  localparam int BETA_W = 14;
  localparam int VREF_W = 14;

  localparam logic [RES_W-1:0]  SERIES_RST  = 20'd6190;
  localparam logic [RES_W-1:0]  NOMINAL_RST = 20'd49120;
  localparam logic [BETA_W-1:0] BETA_RST    = 14'd3977;
  localparam logic [VREF_W-1:0] VREF_RST    = 14'd5070;

  // node voltage scale: 3.3 v * 8.41 / 5.0 in units that keep it integer
  localparam int              VOLT_W   = 15;
  localparam logic [VOLT_W-1:0] VOLT_NUM = 15'd27753;

  // log2 format
  localparam int LOG_FRAC = 24;
  localparam int MANT_W   = 31;

  // ln2 in q32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;

  // 1/298.15 k in q40
  localparam longint unsigned INV_T0_LONG = ((64'd1 << 40) * 64'd100) / 64'd29815;
  localparam logic [31:0]     INV_T0_Q40  = 32'(INV_T0_LONG);

  // ten in q48, numerator of the kelvin reciprocal
  localparam int               KNUM_W  = 52;
  localparam logic [KNUM_W-1:0] TEN_Q48 = 52'd10 << 48;

  // 273.15 k in tenths, q8
  localparam logic [19:0] OFFSET_Q8 = 20'd699264;
  localparam logic [7:0]  ROUND_Q8  = 8'd128;

  // result fields
  localparam int TEMP_W = 12;
  localparam int NODE_W = 13;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = -12'sd99;
  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 12'sd1999;

  // per word classification from the front
  typedef struct packed {
    logic oor;   // zero, infinite or negative resistance
    logic skip;  // zero beta
  } ntc_flags_t;

endpackage

[rtl/ntc_fifo.sv]
// two entry queue between front and back
// generic width, no package use
`timescale 1ns / 1ps

module ntc_fifo #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         valid_o,
  output logic [W-1:0] data_o
);

  logic [W-1:0] mem_q [0:1];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

endmodule

[rtl/ntc_front.sv]
// front: accepts adc words, forms divider numerator and denominator, classifies
// depends on ntc_pkg
`timescale 1ns / 1ps

module ntc_front #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [ADC_BITS-1:0]           code_i,
  output logic                          ready_o,
  input  logic [ntc_pkg::RES_W-1:0]     rs_i,
  input  logic [ntc_pkg::RES_W-1:0]     r0_i,
  input  logic [ntc_pkg::BETA_W-1:0]    beta_i,
  input  logic [ntc_pkg::VREF_W-1:0]    vref_i,
  output logic                          push_o,
  input  logic                          full_i,
  output logic [ntc_pkg::VOLT_W+2*ADC_BITS+17+2-1:0] item_o
);

  localparam int ADC_MAX = (1 << ADC_BITS) - 1;
  localparam int NUM_W   = ntc_pkg::VOLT_W + ADC_BITS;
  localparam int FULL_W  = ADC_BITS + 17;
  localparam int DV_W    = ADC_BITS + 3;
  localparam logic [DV_W-1:0] FIVE_MAX = DV_W'(5 * ADC_MAX);

  typedef logic ntc_flags_chk_t;

  logic                vld_q;
  logic [ADC_BITS-1:0] code_q;
  logic [NUM_W-1:0]    num;
  logic [FULL_W-1:0]   full, den;
  ntc_flags_chk_t      unused_chk;
  ntc_pkg::ntc_flags_t flags;

  assign unused_chk = 1'b0;

  assign ready_o = !vld_q || !full_i;
  assign push_o  = vld_q && !full_i;

  always_comb begin
    num  = NUM_W'(code_q) * NUM_W'(ntc_pkg::VOLT_NUM);
    full = FULL_W'(FIVE_MAX) * FULL_W'(vref_i);
    den  = full - FULL_W'(num);
    flags.oor  = (num == '0) || (rs_i == '0) || (full <= FULL_W'(num)) || (r0_i == '0);
    flags.skip = (beta_i == '0) || unused_chk;
  end

  assign item_o = {num, den, flags};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ready_o) begin
      vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) code_q <= code_i;
  end

endmodule

[rtl/ntc_div.sv]
// pipelined restoring divider, one quotient bit per stage, with sideband
// generic widths, no package use
`timescale 1ns / 1ps

module ntc_div #(
  parameter int N_W  = 8,
  parameter int D_W  = 8,
  parameter int SB_W = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [N_W-1:0]  num_i,
  input  logic [D_W-1:0]  den_i,
  input  logic [SB_W-1:0] sb_i,
  output logic            valid_o,
  output logic [N_W-1:0]  quo_o,
  output logic [SB_W-1:0] sb_o
);

  logic            vld_q [0:N_W-1];
  logic [N_W-1:0]  nq_q  [0:N_W-1];
  logic [D_W-1:0]  rem_q [0:N_W-1];
  logic [D_W-1:0]  den_q [0:N_W-1];
  logic [SB_W-1:0] sb_q  [0:N_W-1];

  for (genvar i = 0; i < N_W; i++) begin : g_stage
    logic            vi;
    logic [N_W-1:0]  nqi;
    logic [D_W-1:0]  remi, deni;
    logic [SB_W-1:0] sbi;
    logic [D_W:0]    sh, dif;
    logic            ge;

    if (i == 0) begin : g_first
      assign vi   = valid_i;
      assign nqi  = num_i;
      assign remi = '0;
      assign deni = den_i;
      assign sbi  = sb_i;
    end else begin : g_next
      assign vi   = vld_q[i-1];
      assign nqi  = nq_q[i-1];
      assign remi = rem_q[i-1];
      assign deni = den_q[i-1];
      assign sbi  = sb_q[i-1];
    end

    // shift in the next numerator bit, trial subtract
    assign sh  = {remi, nqi[N_W-1]};
    assign dif = sh - {1'b0, deni};
    assign ge  = (sh >= {1'b0, deni});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nq_q[i]  <= {nqi[N_W-2:0], ge};
        rem_q[i] <= ge ? dif[D_W-1:0] : sh[D_W-1:0];
        den_q[i] <= deni;
        sb_q[i]  <= sbi;
      end
    end
  end

  assign valid_o = vld_q[N_W-1];
  assign quo_o   = nq_q[N_W-1];
  assign sb_o    = sb_q[N_W-1];

endmodule

[rtl/ntc_log4.sv]
// four lane pipelined log2 in q24: normalize by halving shifts, then squaring steps
// depends on ntc_pkg
`timescale 1ns / 1ps

module ntc_log4 #(
  parameter int X_W  = 27,
  parameter int SB_W = 1,
  localparam int NW    = (X_W > ntc_pkg::MANT_W) ? X_W : ntc_pkg::MANT_W,
  localparam int S     = $clog2(NW),
  localparam int LOG_W = S + ntc_pkg::LOG_FRAC
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic [3:0][X_W-1:0]   x_i,
  input  logic [SB_W-1:0]       sb_i,
  output logic                  valid_o,
  output logic [3:0][LOG_W-1:0] log_o,
  output logic [SB_W-1:0]       sb_o
);

  localparam int MW = ntc_pkg::MANT_W;
  localparam int FW = ntc_pkg::LOG_FRAC;

  // normalize stages
  logic                 nvld_q [0:S-1];
  logic [3:0][NW-1:0]   nrm_q  [0:S-1];
  logic [3:0][S-1:0]    cnt_q  [0:S-1];
  logic [SB_W-1:0]      nsb_q  [0:S-1];

  for (genvar j = 0; j < S; j++) begin : g_norm
    localparam int SH = 1 << (S - 1 - j);
    logic               vi;
    logic [3:0][NW-1:0] ni, nd;
    logic [3:0][S-1:0]  ci, cd;
    logic [SB_W-1:0]    sbi;

    if (j == 0) begin : g_first
      assign vi  = valid_i;
      assign sbi = sb_i;
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign ni[l] = NW'(x_i[l]);
        assign ci[l] = '0;
      end
    end else begin : g_next
      assign vi  = nvld_q[j-1];
      assign sbi = nsb_q[j-1];
      assign ni  = nrm_q[j-1];
      assign ci  = cnt_q[j-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        if (ni[l][NW-1 -: SH] == '0) begin
          nd[l] = ni[l] << SH;
          cd[l] = ci[l] | S'(SH);
        end else begin
          nd[l] = ni[l];
          cd[l] = ci[l];
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nvld_q[j] <= 1'b0;
      end else if (en_i) begin
        nvld_q[j] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        nrm_q[j] <= nd;
        cnt_q[j] <= cd;
        nsb_q[j] <= sbi;
      end
    end
  end

  // squaring stages, one fraction bit each
  logic                svld_q [0:FW-1];
  logic [3:0][MW-1:0]  m_q    [0:FW-1];
  logic [3:0][FW-1:0]  fr_q   [0:FW-1];
  logic [3:0][S-1:0]   k_q    [0:FW-1];
  logic [SB_W-1:0]     ssb_q  [0:FW-1];

  for (genvar i = 0; i < FW; i++) begin : g_sq
    logic               vi;
    logic [3:0][MW-1:0] mi, md;
    logic [3:0][FW-1:0] fi, fd;
    logic [3:0][S-1:0]  ki;
    logic [SB_W-1:0]    sbi;
    logic [3:0][2*MW-1:0] p;

    if (i == 0) begin : g_first
      assign vi  = nvld_q[S-1];
      assign sbi = nsb_q[S-1];
      for (genvar l = 0; l < 4; l++) begin : g_lane
        assign mi[l] = nrm_q[S-1][l][NW-1 -: MW];
        assign fi[l] = '0;
        assign ki[l] = S'(NW - 1) - cnt_q[S-1][l];
      end
    end else begin : g_next
      assign vi  = svld_q[i-1];
      assign sbi = ssb_q[i-1];
      assign mi  = m_q[i-1];
      assign fi  = fr_q[i-1];
      assign ki  = k_q[i-1];
    end

    always_comb begin
      for (int l = 0; l < 4; l++) begin
        p[l]  = (2*MW)'(mi[l]) * (2*MW)'(mi[l]);
        md[l] = p[l][2*MW-1] ? p[l][2*MW-1 -: MW] : p[l][2*MW-2 -: MW];
        fd[l] = {fi[l][FW-2:0], p[l][2*MW-1]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        svld_q[i] <= 1'b0;
      end else if (en_i) begin
        svld_q[i] <= vi;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i]   <= md;
        fr_q[i]  <= fd;
        k_q[i]   <= ki;
        ssb_q[i] <= sbi;
      end
    end
  end

  assign valid_o = svld_q[FW-1];
  assign sb_o    = ssb_q[FW-1];
  for (genvar l = 0; l < 4; l++) begin : g_out
    assign log_o[l] = {k_q[FW-1][l], fr_q[FW-1][l]};
  end

endmodule

[rtl/ntc_back.sv]
// back: node voltage, log ratio, ln over beta, kelvin reciprocal, rounding, clamp
// depends on ntc_pkg, ntc_div, ntc_log4
`timescale 1ns / 1ps

module ntc_back #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF,
  localparam int ITEM_W = ntc_pkg::VOLT_W + 2 * ADC_BITS + 17 + 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [ITEM_W-1:0]                 head_i,
  input  logic                              head_valid_i,
  output logic                              pop_o,
  input  logic [ntc_pkg::RES_W-1:0]         rs_i,
  input  logic [ntc_pkg::RES_W-1:0]         r0_i,
  input  logic [ntc_pkg::BETA_W-1:0]        beta_i,
  input  logic                              ready_i,
  output logic                              valid_o,
  output logic signed [ntc_pkg::TEMP_W-1:0] temp_o,
  output logic [ntc_pkg::NODE_W-1:0]        node_o,
  output logic                              clamped_o,
  output logic                              oor_o
);

  localparam int ADC_MAX = (1 << ADC_BITS) - 1;
  localparam int NUM_W   = ntc_pkg::VOLT_W + ADC_BITS;
  localparam int FULL_W  = ADC_BITS + 17;
  localparam int DV_W    = ADC_BITS + 3;
  localparam logic [DV_W-1:0] FIVE_MAX = DV_W'(5 * ADC_MAX);
  localparam int X_W    = (FULL_W > ntc_pkg::RES_W) ? FULL_W : ntc_pkg::RES_W;
  localparam int NW     = (X_W > ntc_pkg::MANT_W) ? X_W : ntc_pkg::MANT_W;
  localparam int LOG_W  = $clog2(NW) + ntc_pkg::LOG_FRAC;
  localparam int MAG_W  = LOG_W + 1;
  localparam int LN_W   = MAG_W + 16;
  localparam int INV_W  = LN_W + 2;
  localparam int IDV_W  = INV_W - 1;
  localparam int KQ_W   = ntc_pkg::KNUM_W;
  localparam int KP_W   = KQ_W + 1;
  localparam int DIFF_W = KP_W + 1;
  localparam int T_W    = DIFF_W - 8;
  localparam int NODE_W = ntc_pkg::NODE_W;
  localparam int SB2_W  = NODE_W + 2;
  localparam int SB5_W  = NODE_W + 3;
  localparam int SB7_W  = NODE_W + 2;
  localparam logic signed [T_W-1:0] T_LO = T_W'(ntc_pkg::TEMP_MIN);
  localparam logic signed [T_W-1:0] T_HI = T_W'(ntc_pkg::TEMP_MAX);

  // reciprocal of 5 * adc max, exact floor for every numerator below 2^NUM_W
  localparam int NODE_SH = NUM_W + DV_W;
  localparam int RCP_W   = NUM_W + 1;
  localparam longint unsigned RCP_LONG =
    ((64'd1 << NODE_SH) + 64'(FIVE_MAX) - 64'd1) / 64'(FIVE_MAX);
  localparam logic [RCP_W-1:0] NODE_RCP = RCP_W'(RCP_LONG);

  logic en;
  logic valid_q;

  assign en    = !valid_q || ready_i;
  assign pop_o = en && head_valid_i;

  // word register, node voltage by reciprocal multiply
  logic                   v1_q;
  logic [ITEM_W-1:0]      it1_q;
  logic [NUM_W+RCP_W-1:0] nprod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) it1_q <= head_i;
  end

  logic [NUM_W-1:0]    num1;
  logic [FULL_W-1:0]   den1;
  ntc_pkg::ntc_flags_t fl1;
  logic [NODE_W-1:0]   node1;

  assign num1  = it1_q[ITEM_W-1 -: NUM_W];
  assign den1  = it1_q[2 +: FULL_W];
  assign fl1   = it1_q[1:0];
  assign nprod = (NUM_W+RCP_W)'(num1) * (NUM_W+RCP_W)'(NODE_RCP);
  assign node1 = nprod[NODE_SH +: NODE_W];

  // four logs: rs, num, den, r0
  logic                  v2;
  logic [3:0][LOG_W-1:0] lg2;
  logic [SB2_W-1:0]      sb2;
  logic [3:0][X_W-1:0]   lx;

  assign lx = {X_W'(r0_i), X_W'(den1), X_W'(num1), X_W'(rs_i)};

  ntc_log4 #(.X_W(X_W), .SB_W(SB2_W)) u_log (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v1_q), .x_i(lx), .sb_i({node1, fl1}),
    .valid_o(v2), .log_o(lg2), .sb_o(sb2)
  );

  // log ratio magnitude and sign
  logic             v3_q;
  logic [MAG_W-1:0] mag3_q, pos, neg;
  logic             sgn3_q;
  logic [SB2_W-1:0] sb3_q;

  assign pos = MAG_W'(lg2[0]) + MAG_W'(lg2[1]);
  assign neg = MAG_W'(lg2[2]) + MAG_W'(lg2[3]);

  // ln in q40
  logic                v4_q;
  logic [LN_W-1:0]     ln4_q;
  logic                sgn4_q;
  logic [SB2_W-1:0]    sb4_q;
  logic [MAG_W+31:0]   prod;

  assign prod = (MAG_W+32)'(mag3_q) * (MAG_W+32)'(ntc_pkg::LN2_Q32);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sgn3_q <= (pos >= neg);
      mag3_q <= (pos >= neg) ? (pos - neg) : (neg - pos);
      sb3_q  <= sb2;
      ln4_q  <= prod[MAG_W+31:16];
      sgn4_q <= sgn3_q;
      sb4_q  <= sb3_q;
    end
  end

  // ln over beta
  logic             v5;
  logic [LN_W-1:0]  term5;
  logic [SB5_W-1:0] sb5;

  ntc_div #(.N_W(LN_W), .D_W(ntc_pkg::BETA_W), .SB_W(SB5_W)) u_div_beta (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v4_q), .num_i(ln4_q), .den_i(beta_i), .sb_i({sgn4_q, sb4_q}),
    .valid_o(v5), .quo_o(term5), .sb_o(sb5)
  );

  // inverse temperature
  logic                v6_q;
  logic [IDV_W-1:0]    inv6_q;
  logic                bad6_q, oor6_q;
  logic [NODE_W-1:0]   node6_q;
  logic [INV_W-1:0]    inv;
  ntc_pkg::ntc_flags_t fl5;
  logic                inv_pos;

  assign fl5 = sb5[1:0];
  assign inv = sb5[SB5_W-1] ? (INV_W'(ntc_pkg::INV_T0_Q40) + INV_W'(term5))
                            : (INV_W'(ntc_pkg::INV_T0_Q40) - INV_W'(term5));
  assign inv_pos = !inv[INV_W-1] && (inv != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      inv6_q  <= inv[IDV_W-1:0];
      bad6_q  <= fl5.oor || fl5.skip || !inv_pos;
      oor6_q  <= fl5.oor;
      node6_q <= sb5[2 +: NODE_W];
    end
  end

  // kelvin tenths in q8
  logic             v7;
  logic [KQ_W-1:0]  k7;
  logic [SB7_W-1:0] sb7;

  ntc_div #(.N_W(KQ_W), .D_W(IDV_W), .SB_W(SB7_W)) u_div_kelvin (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v6_q), .num_i(ntc_pkg::TEN_Q48), .den_i(inv6_q),
    .sb_i({node6_q, oor6_q, bad6_q}),
    .valid_o(v7), .quo_o(k7), .sb_o(sb7)
  );

  // round half up, to celsius, clamp
  logic [KP_W-1:0]          kp;
  logic signed [DIFF_W-1:0] diff;
  logic signed [T_W-1:0]    t;

  assign kp   = KP_W'(k7) + KP_W'(ntc_pkg::ROUND_Q8);
  assign diff = DIFF_W'(kp) - DIFF_W'(ntc_pkg::OFFSET_Q8);
  assign t    = diff[DIFF_W-1:8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= v7;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && v7) begin
      node_o <= sb7[2 +: NODE_W];
      oor_o  <= sb7[1];
      priority if (sb7[0]) begin
        temp_o    <= ntc_pkg::TEMP_MIN;
        clamped_o <= 1'b1;
      end else if (t < T_LO) begin
        temp_o    <= ntc_pkg::TEMP_MIN;
        clamped_o <= 1'b1;
      end else if (t > T_HI) begin
        temp_o    <= ntc_pkg::TEMP_MAX;
        clamped_o <= 1'b1;
      end else begin
        temp_o    <= t[ntc_pkg::TEMP_W-1:0];
        clamped_o <= 1'b0;
      end
    end
  end

  assign valid_o = valid_q;

endmodule

[rtl/thermistor_adc_to_temperature.sv]
// top level: configuration registers, front, queue and back of the ntc converter
// depends on ntc_pkg, ntc_front, ntc_fifo, ntc_back
`timescale 1ns / 1ps

// ntc thermistor converter, beta equation. each adc word on the slave stream gives
// one result word on the master stream: temperature in tenths of a degree celsius
// (rounded, clamped to -99..1999), the undivided node voltage in millivolts
// (truncated), a clamp flag and an out of range flag for zero, infinite or
// negative resistance (those read -99 with both flags set). the whole path is a
// fully pipelined datapath: one word per clock sustained while the master stream
// takes results. a word accepted passes the front register and the queue, then
// 1 + clog2(NW) + 24 + LN_W + 56 register stages through the back; the length is
// set by the bit-per-stage dividers (ln over beta, kelvin reciprocal) and the 24
// squaring stages of the log2 lanes; the node voltage uses a reciprocal multiply.
// a waiting result stalls the whole back; the two word queue and the front
// register then take up to three more words before s_tready_o drops.
// configuration is a plain write port, to be written only while the block is
// idle.

module thermistor_adc_to_temperature #(
  parameter int ADC_BITS = ntc_pkg::ADC_BITS_DEF,
  localparam int IN_W = ((ADC_BITS + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ntc_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [ntc_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [IN_W-1:0]               s_tdata_i,   // adc_code
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [31:0]                   m_tdata_o,   // temperature_decidegrees, node_millivolts
  output logic [1:0]                    m_tuser_o    // clamped, out_of_range
);

  localparam int ITEM_W = ntc_pkg::VOLT_W + 2 * ADC_BITS + 17 + 2;

  // configuration registers
  logic [ntc_pkg::RES_W-1:0]  rs_q, r0_q;
  logic [ntc_pkg::BETA_W-1:0] beta_q;
  logic [ntc_pkg::VREF_W-1:0] vref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q   <= ntc_pkg::SERIES_RST;
      r0_q   <= ntc_pkg::NOMINAL_RST;
      beta_q <= ntc_pkg::BETA_RST;
      vref_q <= ntc_pkg::VREF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ntc_pkg::REG_SERIES:  rs_q   <= cfg_data_i[ntc_pkg::RES_W-1:0];
        ntc_pkg::REG_NOMINAL: r0_q   <= cfg_data_i[ntc_pkg::RES_W-1:0];
        ntc_pkg::REG_BETA:    beta_q <= cfg_data_i[ntc_pkg::BETA_W-1:0];
        ntc_pkg::REG_VREF:    vref_q <= cfg_data_i[ntc_pkg::VREF_W-1:0];
        default: ;
      endcase
    end
  end

  // front: classify, form numerator and denominator
  logic              push, full;
  logic [ITEM_W-1:0] item_in;

  ntc_front #(.ADC_BITS(ADC_BITS)) u_front (
    .clk_i, .rst_ni,
    .valid_i(s_tvalid_i), .code_i(s_tdata_i[ADC_BITS-1:0]), .ready_o(s_tready_o),
    .rs_i(rs_q), .r0_i(r0_q), .beta_i(beta_q), .vref_i(vref_q),
    .push_o(push), .full_i(full), .item_o(item_in)
  );

  // queue between the two halves
  logic              pop, head_valid;
  logic [ITEM_W-1:0] head;

  ntc_fifo #(.W(ITEM_W)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .data_i(item_in), .full_o(full),
    .pop_i(pop), .valid_o(head_valid), .data_o(head)
  );

  // back: arithmetic pipeline and output register
  logic signed [ntc_pkg::TEMP_W-1:0] temp;
  logic [ntc_pkg::NODE_W-1:0]        node;
  logic                              clamped, oor;

  ntc_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk_i, .rst_ni,
    .head_i(head), .head_valid_i(head_valid), .pop_o(pop),
    .rs_i(rs_q), .r0_i(r0_q), .beta_i(beta_q),
    .ready_i(m_tready_i), .valid_o(m_tvalid_o),
    .temp_o(temp), .node_o(node), .clamped_o(clamped), .oor_o(oor)
  );

  assign m_tdata_o = {7'b0, node, temp};
  assign m_tuser_o = {oor, clamped};

  // out of range always reports the low clamp
  a_oor_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && oor |-> clamped && (temp == ntc_pkg::TEMP_MIN))
    else $error("out of range word without low clamp");

  // a clamped word sits on one of the limits
  a_clamp_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && clamped |-> (temp == ntc_pkg::TEMP_MIN) || (temp == ntc_pkg::TEMP_MAX))
    else $error("clamped word off the limits");

  // unclamped temperature stays inside the range
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !clamped |-> (temp >= ntc_pkg::TEMP_MIN) && (temp <= ntc_pkg::TEMP_MAX))
    else $error("unclamped temperature out of range");

  // queue only pops what it holds and is not pushed while full
  a_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid && !(push && full))
    else $error("queue popped empty or pushed full");

endmodule
